// ===== sv/ifs_pkg.sv =====
`default_nettype none

package ifs_pkg;

    // field and scaling constants
    localparam int FIELD_W    = 16;
    localparam int COORD_BITS = 16;
    localparam int SCALE      = 1024;
    localparam int SCORE_W    = 26;

    // squared distance: two squares of COORD_BITS-bit values plus a carry
    localparam int DSQ_W     = 2 * COORD_BITS + 1;
    localparam int SCL_LOG   = $clog2(SCALE);
    localparam int SSQ_W     = 2 * SCL_LOG + 1;
    localparam logic [SSQ_W-1:0] SCALE_SQ = SSQ_W'(SCALE * SCALE);

    // radicand padded to an even width, root takes half of it
    localparam int SCALED_W  = DSQ_W + 2 * SCL_LOG;
    localparam int RAD_W     = SCALED_W + (SCALED_W % 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int LOSS_W    = FIELD_W + ROOT_W;

    // one beat as it travels along the root cells
    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [RAD_W-1:0]   rad;
        logic [FIELD_W-1:0] strength;
        logic [FIELD_W-1:0] decay;
    } ifs_sq_t;

endpackage

`default_nettype wire

// ===== sv/ifs_front.sv =====
`default_nettype none

module ifs_front
    import ifs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FIELD_W-1:0] source_row,
    input  wire logic [FIELD_W-1:0] source_col,
    input  wire logic [FIELD_W-1:0] cell_row,
    input  wire logic [FIELD_W-1:0] cell_col,
    input  wire logic [FIELD_W-1:0] strength,
    input  wire logic [FIELD_W-1:0] decay,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ifs_sq_t                 out_sq
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [COORD_BITS-1:0] dr_reg, dc_reg;
    logic [FIELD_W-1:0]    str1_reg, dec1_reg;
    logic [2*COORD_BITS-1:0] sqr_reg, sqc_reg;
    logic [FIELD_W-1:0]    str2_reg, dec2_reg;
    ifs_sq_t               sq_reg;

    logic [COORD_BITS-1:0] sr, sc, cr, cc;
    logic [COORD_BITS-1:0] dr_next, dc_next;
    logic [DSQ_W-1:0]      dsq;
    ifs_sq_t               sq_next;

    // per-stage ready, bubbles collapse
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // absolute coordinate differences
    always_comb
    begin
        sr = source_row[COORD_BITS-1:0];
        sc = source_col[COORD_BITS-1:0];
        cr = cell_row[COORD_BITS-1:0];
        cc = cell_col[COORD_BITS-1:0];
        dr_next = (sr >= cr) ? (sr - cr) : (cr - sr);
        dc_next = (sc >= cc) ? (sc - cc) : (cc - sc);
    end

    // sum of squares scaled into the radicand
    always_comb
    begin
        dsq              = DSQ_W'(sqr_reg) + DSQ_W'(sqc_reg);
        sq_next.rem      = '0;
        sq_next.root     = '0;
        sq_next.rad      = RAD_W'(SCALED_W'(dsq) * SCALED_W'(SCALE_SQ));
        sq_next.strength = str2_reg;
        sq_next.decay    = dec2_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            dr_reg   <= dr_next;
            dc_reg   <= dc_next;
            str1_reg <= strength;
            dec1_reg <= decay;
        end
        if (rdy2 && v1_reg)
        begin
            sqr_reg  <= dr_reg * dr_reg;
            sqc_reg  <= dc_reg * dc_reg;
            str2_reg <= str1_reg;
            dec2_reg <= dec1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sq_reg <= sq_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_sq    = sq_reg;

endmodule

`default_nettype wire

// ===== sv/ifs_root_cell.sv =====
`default_nettype none

module ifs_root_cell
    import ifs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire ifs_sq_t in_sq,
    output logic         out_valid,
    input  wire logic    out_ready,
    output ifs_sq_t      out_sq
);

    logic    v_reg;
    logic    rdy;
    ifs_sq_t sq_reg;
    ifs_sq_t sq_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    // one root digit: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh = {in_sq.rem[REM_W-3:0], in_sq.rad[RAD_W-1:RAD_W-2]};
        trial  = {in_sq.root, 2'b01};
        take   = (rem_sh >= trial);
        sq_next          = in_sq;
        sq_next.rem      = take ? (rem_sh - trial) : rem_sh;
        sq_next.root     = {in_sq.root[ROOT_W-2:0], take};
        sq_next.rad      = {in_sq.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_valid)
            sq_reg <= sq_next;
    end

    assign out_valid = v_reg;
    assign out_sq    = sq_reg;

endmodule

`default_nettype wire

// ===== sv/ifs_back.sv =====
`default_nettype none

module ifs_back
    import ifs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ifs_sq_t            in_sq,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SCORE_W-1:0]      score
);

    logic v1_reg, v2_reg;
    logic rdy1, rdy2;

    logic [SCORE_W-1:0] peak_reg;
    logic [LOSS_W-1:0]  loss_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [LOSS_W-1:0]  peak_wide;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // peak minus loss, clamped at zero
    always_comb
    begin
        peak_wide  = LOSS_W'(peak_reg);
        score_next = (peak_wide > loss_reg) ? SCORE_W'(peak_wide - loss_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    // decay times distance, then the output register
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            peak_reg <= SCORE_W'(32'(in_sq.strength) * SCALE);
            loss_reg <= LOSS_W'(in_sq.decay) * LOSS_W'(in_sq.root);
        end
        if (rdy2 && v1_reg)
            score_reg <= score_next;
    end

    assign out_valid = v2_reg;
    assign score     = score_reg;

endmodule

`default_nettype wire

// ===== sv/influence_falloff_score_unit.sv =====
// influence falloff score unit
// input channel: in_valid / in_ready with source_row, source_col, cell_row,
// cell_col, strength and decay; one beat per source/cell pair
// output channel: out_valid / out_ready with score, one beat per input beat,
// in input order
// score = max(0, strength*1024 - decay*dist), dist being the floor square
// root of the squared euclidean distance times 1024 squared
// pipeline: difference, square and scale stages, then 27 root cells with
// one root bit each, then multiply and clamp stages
// throughput: one beat per cycle; every stage is a register with its own
// valid bit, so a new beat enters each cycle the output is taken
// stall: when out_ready is low the last stage holds its beat; earlier
// stages keep filling empty slots, and in_ready drops only once the whole
// chain is full
// reset: rst_n clears all valid bits; the payload registers are not reset
`default_nettype none

module influence_falloff_score_unit
    import ifs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FIELD_W-1:0] source_row,
    input  wire logic [FIELD_W-1:0] source_col,
    input  wire logic [FIELD_W-1:0] cell_row,
    input  wire logic [FIELD_W-1:0] cell_col,
    input  wire logic [FIELD_W-1:0] strength,
    input  wire logic [FIELD_W-1:0] decay,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SCORE_W-1:0]      score
);

    ifs_sq_t chain_sq    [ROOT_W+1];
    logic    chain_valid [ROOT_W+1];
    logic    chain_ready [ROOT_W+1];

    // differences, squares and scaling
    ifs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .source_row (source_row),
        .source_col (source_col),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .strength   (strength),
        .decay      (decay),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_sq     (chain_sq[0])
    );

    // square root, one cell per root bit
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        ifs_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_sq     (chain_sq[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_sq    (chain_sq[i+1])
        );
    end

    // loss and clamp
    ifs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[ROOT_W]),
        .in_ready  (chain_ready[ROOT_W]),
        .in_sq     (chain_sq[ROOT_W]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .score     (score)
    );

endmodule

`default_nettype wire
